### hdl/pfa_pkg.sv
// Shared widths, result codes and field types of the polygon perimeter and area block.
`timescale 1ns / 1ps

package pfa_pkg;

   localparam int PERIM_W = 30;
   localparam int AREA_W  = 40;
   localparam int INDEX_W = 6;

   localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};
   localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};

   localparam logic KIND_TRIANGLE = 1'b0;
   localparam logic KIND_TOTALS   = 1'b1;

   typedef logic [PERIM_W-1:0] perim_type;
   typedef logic [AREA_W-1:0]  area_type;
   typedef logic [INDEX_W-1:0] index_type;

endpackage

### hdl/pfa_req_if.sv
// Request and response channel interfaces of the polygon perimeter and area block.
`timescale 1ns / 1ps

interface pfa_req_if #(parameter int COORD_BITS = 16) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic                         last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                   output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      result_kind;
   index_type triangle_index;
   area_type  area_value;
   perim_type perimeter;
   logic      last_of_run;

   modport source (output valid, output result_kind, output triangle_index,
                   output area_value, output perimeter, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input triangle_index,
                   input area_value, input perimeter, input last_of_run, output ready);
endinterface

### hdl/pfa_alu.sv
// Shared wide adder and subtractor used by the multiply and square root sequences.
`timescale 1ns / 1ps

module pfa_alu #(
   parameter int W = 92
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         sub,
   output logic [W-1:0] sum,
   output logic         carry
);

   // With sub set, carry high means a >= b (no borrow).
   logic [W:0] full;

   assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);
   assign sum   = full[W-1:0];
   assign carry = full[W];

endmodule

### hdl/polygon_perimeter_fan_area.sv
// Top level: vertex sequencer computing edge lengths, fan triangle areas and totals.
`timescale 1ns / 1ps

// Polygon perimeter and fan area.
//
// Vertices arrive on the req_chan channel, one request per vertex, as signed
// coordinates with a last flag. Results leave on rsp_chan. From the third vertex
// on, each vertex produces one triangle result (the fan triangle first, previous,
// current, area by Heron's formula). The last vertex, or the vertex that reaches
// MAX_VERTICES, also produces a totals result with the area sum and perimeter.
//
// Multiplications, square roots and edge sums run on one shared wide adder.
// Multiplications are shift and add, one multiplier bit per cycle; square roots
// are restoring, one result bit per cycle. An edge squares dx and dy, adds them
// and takes a root; a fan triangle multiplies the Heron factors and takes a root.
// The block accepts one request at a time: req_chan.ready is high only while it
// is idle. A result is held in an output register until the receiver takes it;
// a stalled receiver simply holds the sequencer in its output state.
// Synchronous reset returns the block to idle with an empty polygon.

module polygon_perimeter_fan_area
   import pfa_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic      clock,
   input  logic      reset,
   pfa_req_if.sink   req_chan,
   pfa_rsp_if.source rsp_chan
);

   localparam int CB  = COORD_BITS;
   localparam int E   = CB + 5;            // edge length width, 4 fraction bits
   localparam int FW  = E + 3;             // signed Heron factor width
   localparam int MB  = 2 * E + 4;         // multiplier operand width
   localparam int W   = 4 * E + 8;         // shared adder width
   localparam int RW  = W / 2;             // square root result width
   localparam int AW  = RW - 10;           // triangle area width
   localparam int SAW = ((AW > AREA_W) ? AW : AREA_W) + 1;
   localparam int CW  = $clog2(MAX_VERTICES);
   localparam int NW  = $clog2(RW + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_SQRT  = 4'd2;
   localparam logic [3:0] S_E_A   = 4'd3;
   localparam logic [3:0] S_E_B   = 4'd4;
   localparam logic [3:0] S_E_C   = 4'd5;
   localparam logic [3:0] S_E_D   = 4'd6;
   localparam logic [3:0] S_H_A   = 4'd7;
   localparam logic [3:0] S_H_B   = 4'd8;
   localparam logic [3:0] S_H_C   = 4'd9;
   localparam logic [3:0] S_H_D   = 4'd10;
   localparam logic [3:0] S_H_E   = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;
   localparam logic [3:0] S_OUT_T = 4'd13;
   localparam logic [3:0] S_OUT_S = 4'd14;

   logic [3:0]    state_ff, state_in, ret_ff, ret_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in, rad_ff, rad_in, root_ff, root_in, tmp_ff, tmp_in;
   logic [MB-1:0] mcand_ff, mcand_in, mplier_ff, mplier_in;
   logic signed [CB-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [CB-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [CB-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic          last_ff, last_in, edge_sel_ff, edge_sel_in;
   logic [CW-1:0] idx_ff, idx_in, count_ff, count_in;
   perim_type     perim_ff, perim_in;
   area_type      area_ff, area_in;
   logic [E-1:0]  fan_ff, fan_in, e_ff, e_in, c_ff, c_in;
   logic [E+1:0]  f3_ff, f3_in, f4_ff, f4_in;
   logic          kind_ff, kind_in, lor_ff, lor_in;
   index_type     tidx_ff, tidx_in;
   area_type      aout_ff, aout_in;
   perim_type     pout_ff, pout_in;

   logic [W-1:0]  alu_a, alu_b, alu_sum;
   logic          alu_sub, alu_carry;

   logic signed [CB:0] dx, dy;
   logic [CB:0]        mag_x, mag_y;
   logic signed [FW-1:0] fa, fb, fc, g1, g2, g3, g4;
   logic [W-1:0]       rem_sh, trial;
   logic [AW-1:0]      tri_area;
   logic [SAW-1:0]     area_sum_w;
   logic [E-1:0]       close_len;
   logic [CW:0]        count_next;

   pfa_alu #(.W(W)) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .sub   (alu_sub),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   function automatic perim_type sat_perim(input perim_type s, input logic [E-1:0] v);
      logic [PERIM_W:0] t;
      t = {1'b0, s} + (PERIM_W+1)'(v);
      sat_perim = t[PERIM_W] ? PERIM_MAX : t[PERIM_W-1:0];
   endfunction

   // Coordinate differences for the edge being measured.
   always_comb begin
      if (edge_sel_ff) begin
         dx = $signed({first_x_ff[CB-1], first_x_ff}) - $signed({cur_x_ff[CB-1], cur_x_ff});
         dy = $signed({first_y_ff[CB-1], first_y_ff}) - $signed({cur_y_ff[CB-1], cur_y_ff});
      end else begin
         dx = $signed({prev_x_ff[CB-1], prev_x_ff}) - $signed({cur_x_ff[CB-1], cur_x_ff});
         dy = $signed({prev_y_ff[CB-1], prev_y_ff}) - $signed({cur_y_ff[CB-1], cur_y_ff});
      end
      mag_x = dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
      mag_y = dy[CB] ? (CB+1)'(-dy) : (CB+1)'(dy);
   end

   // Heron factors: sides a = fan side, b = new edge, c = first to current.
   always_comb begin
      fa = $signed({3'b000, fan_ff});
      fb = $signed({3'b000, e_ff});
      fc = $signed({3'b000, c_ff});
      g1 = fa + fb + fc;
      g2 = fb + fc - fa;
      g3 = fa + fc - fb;
      g4 = fa + fb - fc;
   end

   assign rem_sh     = {acc_ff[W-3:0], rad_ff[W-1:W-2]};
   assign trial      = {root_ff[W-3:0], 2'b01};
   assign tri_area   = root_ff[RW-1:10];
   assign area_sum_w = SAW'(area_ff) + SAW'(tri_area);
   assign count_next = {1'b0, count_ff} + (CW+1)'(1);
   assign close_len  = (idx_ff == '0) ? '0 : ((idx_ff == CW'(1)) ? e_ff : c_ff);

   // Operand selection for the shared adder.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_MUL: begin
            alu_a = {acc_ff[W-2:0], 1'b0};
            alu_b = mplier_ff[MB-1] ? W'(mcand_ff) : '0;
         end
         S_SQRT: begin
            alu_a   = rem_sh;
            alu_b   = trial;
            alu_sub = 1'b1;
         end
         S_E_C: begin
            alu_a = acc_ff;
            alu_b = tmp_ff;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      rad_in      = rad_ff;
      root_in     = root_ff;
      tmp_in      = tmp_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      first_x_in  = first_x_ff;
      first_y_in  = first_y_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      last_in     = last_ff;
      edge_sel_in = edge_sel_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      perim_in    = perim_ff;
      area_in     = area_ff;
      fan_in      = fan_ff;
      e_in        = e_ff;
      c_in        = c_ff;
      f3_in       = f3_ff;
      f4_in       = f4_ff;
      kind_in     = kind_ff;
      lor_in      = lor_ff;
      tidx_in     = tidx_ff;
      aout_in     = aout_ff;
      pout_in     = pout_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cur_x_in    = req_chan.vertex_x;
               cur_y_in    = req_chan.vertex_y;
               last_in     = req_chan.last_vertex ||
                             (count_next >= (CW+1)'(MAX_VERTICES));
               idx_in      = count_ff;
               edge_sel_in = 1'b0;
               if (count_ff == '0) begin
                  first_x_in = req_chan.vertex_x;
                  first_y_in = req_chan.vertex_y;
                  state_in   = S_FIN;
               end else begin
                  state_in = S_E_A;
               end
            end
         end
         S_MUL: begin
            acc_in    = alu_sum;
            mplier_in = {mplier_ff[MB-2:0], 1'b0};
            cnt_in    = cnt_ff - NW'(1);
            if (cnt_ff == NW'(1)) begin
               state_in = ret_ff;
            end
         end
         S_SQRT: begin
            rad_in = {rad_ff[W-3:0], 2'b00};
            cnt_in = cnt_ff - NW'(1);
            if (alu_carry) begin
               acc_in  = alu_sum;
               root_in = {root_ff[W-2:0], 1'b1};
            end else begin
               acc_in  = rem_sh;
               root_in = {root_ff[W-2:0], 1'b0};
            end
            if (cnt_ff == NW'(1)) begin
               state_in = ret_ff;
            end
         end
         S_E_A: begin
            mcand_in  = MB'(mag_x);
            mplier_in = {mag_x, {(MB-CB-1){1'b0}}};
            acc_in    = '0;
            cnt_in    = NW'(CB + 1);
            ret_in    = S_E_B;
            state_in  = S_MUL;
         end
         S_E_B: begin
            tmp_in    = acc_ff;
            mcand_in  = MB'(mag_y);
            mplier_in = {mag_y, {(MB-CB-1){1'b0}}};
            acc_in    = '0;
            cnt_in    = NW'(CB + 1);
            ret_in    = S_E_C;
            state_in  = S_MUL;
         end
         S_E_C: begin
            // Radicand (dx^2 + dy^2) << 8, aligned to the top of the shifter.
            rad_in   = {alu_sum[2*CB+1:0], {(W-2*CB-2){1'b0}}};
            acc_in   = '0;
            root_in  = '0;
            cnt_in   = NW'(CB + 5);
            ret_in   = S_E_D;
            state_in = S_SQRT;
         end
         S_E_D: begin
            if (edge_sel_ff) begin
               c_in     = root_ff[E-1:0];
               state_in = S_H_A;
            end else begin
               e_in     = root_ff[E-1:0];
               perim_in = sat_perim(perim_ff, root_ff[E-1:0]);
               if (idx_ff == CW'(1)) begin
                  fan_in   = root_ff[E-1:0];
                  state_in = S_FIN;
               end else begin
                  edge_sel_in = 1'b1;
                  state_in    = S_E_A;
               end
            end
         end
         S_H_A: begin
            f3_in = g3[E+1:0];
            f4_in = g4[E+1:0];
            if (g2[FW-1] || g3[FW-1] || g4[FW-1]) begin
               // Degenerate triangle from rounding: area is zero.
               root_in  = '0;
               state_in = S_H_E;
            end else begin
               mcand_in  = MB'(g1[E+1:0]);
               mplier_in = {g2[E+1:0], {(MB-E-2){1'b0}}};
               acc_in    = '0;
               cnt_in    = NW'(E + 2);
               ret_in    = S_H_B;
               state_in  = S_MUL;
            end
         end
         S_H_B: begin
            tmp_in    = acc_ff;
            mplier_in = {f4_ff, {(MB-E-2){1'b0}}};
            mcand_in  = MB'(f3_ff);
            acc_in    = '0;
            cnt_in    = NW'(E + 2);
            ret_in    = S_H_C;
            state_in  = S_MUL;
         end
         S_H_C: begin
            mcand_in  = tmp_ff[MB-1:0];
            mplier_in = acc_ff[MB-1:0];
            acc_in    = '0;
            cnt_in    = NW'(MB);
            ret_in    = S_H_D;
            state_in  = S_MUL;
         end
         S_H_D: begin
            rad_in   = acc_ff;
            acc_in   = '0;
            root_in  = '0;
            cnt_in   = NW'(RW);
            ret_in   = S_H_E;
            state_in = S_SQRT;
         end
         S_H_E: begin
            area_in  = (area_sum_w > SAW'(AREA_MAX)) ? AREA_MAX : area_sum_w[AREA_W-1:0];
            fan_in   = c_ff;
            kind_in  = KIND_TRIANGLE;
            tidx_in  = INDEX_W'(idx_ff - CW'(1));
            aout_in  = AREA_W'(tri_area);
            pout_in  = '0;
            lor_in   = !last_ff;
            state_in = S_OUT_T;
         end
         S_FIN: begin
            if (last_ff) begin
               kind_in    = KIND_TOTALS;
               tidx_in    = '0;
               aout_in    = area_ff;
               pout_in    = sat_perim(perim_ff, close_len);
               lor_in     = 1'b1;
               count_in   = '0;
               perim_in   = '0;
               area_in    = '0;
               fan_in     = '0;
               first_x_in = '0;
               first_y_in = '0;
               prev_x_in  = '0;
               prev_y_in  = '0;
               state_in   = S_OUT_S;
            end else begin
               count_in  = count_next[CW-1:0];
               prev_x_in = cur_x_ff;
               prev_y_in = cur_y_ff;
               state_in  = S_IDLE;
            end
         end
         S_OUT_T: begin
            if (rsp_chan.ready) begin
               state_in = S_FIN;
            end
         end
         S_OUT_S: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         perim_ff   <= '0;
         area_ff    <= '0;
         fan_ff     <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         perim_ff   <= perim_in;
         area_ff    <= area_in;
         fan_ff     <= fan_in;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      tmp_ff      <= tmp_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      last_ff     <= last_in;
      edge_sel_ff <= edge_sel_in;
      idx_ff      <= idx_in;
      e_ff        <= e_in;
      c_ff        <= c_in;
      f3_ff       <= f3_in;
      f4_ff       <= f4_in;
      kind_ff     <= kind_in;
      lor_ff      <= lor_in;
      tidx_ff     <= tidx_in;
      aout_ff     <= aout_in;
      pout_ff     <= pout_in;
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = (state_ff == S_OUT_T) || (state_ff == S_OUT_S);
   assign rsp_chan.result_kind    = kind_ff;
   assign rsp_chan.triangle_index = tidx_ff;
   assign rsp_chan.area_value     = aout_ff;
   assign rsp_chan.perimeter      = pout_ff;
   assign rsp_chan.last_of_run    = lor_ff;

endmodule

### hdl/pfa_checker.sv
// Port-level checks of the polygon perimeter and area block, bound to the top level.
`timescale 1ns / 1ps

module pfa_checker
   import pfa_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input logic      result_kind,
   input index_type triangle_index,
   input perim_type perimeter,
   input logic      last_of_run
);

   // A pending response holds until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // No new request is taken while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while a response is pending");

   // Totals always close the run and carry no triangle number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (result_kind == KIND_TOTALS) |-> last_of_run && (triangle_index == '0))
      else $error("malformed totals response");

   // Triangle responses carry no perimeter.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (result_kind == KIND_TRIANGLE) |-> (perimeter == '0))
      else $error("triangle response with nonzero perimeter");

   // A totals response is followed by readiness for a new polygon once taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (result_kind == KIND_TOTALS) |=> req_ready)
      else $error("block not idle after totals");

endmodule

bind polygon_perimeter_fan_area pfa_checker u_pfa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .result_kind    (rsp_chan.result_kind),
   .triangle_index (rsp_chan.triangle_index),
   .perimeter      (rsp_chan.perimeter),
   .last_of_run    (rsp_chan.last_of_run)
);
